[design/fsdt_pkg.sv]
// ----------------------------------------------------------------------------
// fsdt_pkg: shared types for the feed sequence / de-dup / tally block
// Sequencer states and control groups for the channel and symbol cells.
// ----------------------------------------------------------------------------
`default_nettype none
package fsdt_pkg;

    localparam int KindW = 2;
    localparam int ChanW = 16;
    localparam int SeqW  = 32;
    localparam int IdW   = 64;
    localparam int SymW  = 64;
    localparam int QtyW  = 32;
    localparam int CntW  = 32;
    localparam int SumW  = 64;

    localparam logic [KindW-1:0] KIND_EXEC = 2'd0;
    localparam logic [KindW-1:0] KIND_EOD  = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_SCAN,
        S_SYM,
        S_RES
    } t_state;

    // broadcast to every channel cell
    typedef struct packed {
        logic             upd;     // update the hit cell's last sequence
        logic [ChanW-1:0] key;
        logic [SeqW-1:0]  seq;
    } t_chan_ctl;

    // broadcast to every symbol cell
    typedef struct packed {
        logic             upd;     // tally step this cycle
        logic             miss;    // no cell holds the key
        logic             exec;    // add a trade and the quantity
        logic [SymW-1:0]  key;
        logic [SumW-1:0]  qty;
    } t_sym_ctl;

endpackage
`default_nettype wire

[design/fsdt_ram.sv]
// ----------------------------------------------------------------------------
// fsdt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fsdt_ram #(
    parameter int W = 64,
    parameter int D = 256,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[design/fsdt_chan_cell.sv]
// ----------------------------------------------------------------------------
// fsdt_chan_cell: one channel slot
// Holds a channel key and its last sequence number; matches the broadcast key.
// ----------------------------------------------------------------------------
`default_nettype none
module fsdt_chan_cell
    import fsdt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_live,    // slot index below used count
    input  wire logic            i_alloc,   // claim this slot
    input  wire t_chan_ctl       i_ctl,
    output logic                 o_hit,
    output logic [SeqW-1:0]      o_last
);

    logic [ChanW-1:0] r_key;
    logic [SeqW-1:0]  r_last;

    assign o_hit  = i_live && (r_key == i_ctl.key);
    assign o_last = r_last;

    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_key  <= i_ctl.key;
            r_last <= i_ctl.seq;
        end else if (i_ctl.upd && o_hit) begin
            r_last <= i_ctl.seq;
        end
    end

endmodule
`default_nettype wire

[design/fsdt_sym_cell.sv]
// ----------------------------------------------------------------------------
// fsdt_sym_cell: one symbol tally slot
// Key, saturating trade count and wrapping quantity sum; free-slot chain.
// ----------------------------------------------------------------------------
`default_nettype none
module fsdt_sym_cell
    import fsdt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_sym_ctl        i_ctl,
    input  wire logic            i_free_in,  // a free slot exists to the left
    output logic                 o_free_out,
    output logic                 o_hit,
    output logic [CntW-1:0]      o_trades,
    output logic [SumW-1:0]      o_qty
);

    logic            r_used;
    logic [SymW-1:0] r_key;
    logic [CntW-1:0] r_trades;
    logic [SumW-1:0] r_qty;
    logic            w_take;

    assign o_hit      = r_used && (r_key == i_ctl.key);
    assign o_free_out = i_free_in || !r_used;
    assign w_take     = !r_used && !i_free_in && i_ctl.upd && i_ctl.miss;
    assign o_trades   = r_trades;
    assign o_qty      = r_qty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (w_take) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key    <= i_ctl.key;
            r_trades <= i_ctl.exec ? CntW'(1) : '0;
            r_qty    <= i_ctl.exec ? i_ctl.qty : '0;
        end else if (i_ctl.upd && i_ctl.exec && o_hit) begin
            if (r_trades != '1) begin
                r_trades <= r_trades + CntW'(1);
            end
            r_qty <= r_qty + i_ctl.qty;
        end
    end

endmodule
`default_nettype wire

[design/feed_sequence_dedup_tally.sv]
// ----------------------------------------------------------------------------
// feed_sequence_dedup_tally: feed sequence check, exec de-dup and tally
// Top level: sequencer, channel cells, symbol cells and the exec id RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one parsed message per beat. tuser carries msg_kind,
//    tdata the remaining fields. Master stream: one result beat per message.
//  - One message is in work at a time. Per message: channel check; for an
//    execution with an id, a scan of the stored ids through the RAM read
//    port; a symbol tally for end of day and for a new id that is stored;
//    result load.
//  - Channel and symbol tables are rows of cells compared in parallel;
//    free symbol slots are found through a chain from cell 0 upward.
//  - The result sits in an output register; the next message is taken while
//    it waits. A stalled receiver holds the sequencer at the result step.
//  - Reset (synchronous, active low) empties all tables at once: counts and
//    symbol used bits clear, no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module feed_sequence_dedup_tally
    import fsdt_pkg::*;
#(
    parameter int CHANNEL_SLOTS = 3,
    parameter int SYMBOL_SLOTS  = 16,
    parameter int DEDUP_SLOTS   = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // channel_present, channel_id, seq_present, seq_number, exec_id_present,
    // exec_id, symbol_key, qty_present, quantity, 4 zero bits
    input  wire logic [215:0] i_s_tdata,
    // msg_kind
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // seq_checked, gap_detected, expected_seq, is_new_trade, tally_valid,
    // trades, total_quantity, 4 zero bits
    output logic [135:0]      o_m_tdata
);

    localparam int CCW = $clog2(CHANNEL_SLOTS + 1);
    localparam int DCW = $clog2(DEDUP_SLOTS + 1);
    localparam int DAW = (DEDUP_SLOTS > 1) ? $clog2(DEDUP_SLOTS) : 1;

    t_state r_state, n_state;

    // latched message
    logic [KindW-1:0] r_kind;
    logic             r_ch_ok;
    logic [ChanW-1:0] r_ch;
    logic [SeqW-1:0]  r_seq;
    logic             r_id_ok;
    logic [IdW-1:0]   r_id;
    logic [SymW-1:0]  r_sym;
    logic [SumW-1:0]  r_qty;

    // result in progress
    logic             r_checked, r_gap, r_new, r_tally;
    logic [SeqW-1:0]  r_expect;

    // counts
    logic [CCW-1:0]   r_chan_cnt;
    logic [DCW-1:0]   r_seen_cnt;

    // id scan
    logic [DCW-1:0]   r_addr;
    logic             r_pend;
    logic [IdW-1:0]   w_rdata;
    logic             w_we;

    // output register
    logic             r_out_valid;
    logic [135:0]     r_out_data;

    // ---------------- channel cells ----------------
    t_chan_ctl              w_cctl;
    logic [CHANNEL_SLOTS-1:0] w_chit;
    logic [SeqW-1:0]        w_clast [CHANNEL_SLOTS];
    logic [SeqW-1:0]        w_chit_last;
    logic                   w_chan_step;
    logic                   w_chan_alloc;

    assign w_chan_step  = (r_state == S_CHAN) && r_ch_ok;
    assign w_chan_alloc = w_chan_step && (w_chit == '0)
                          && (r_chan_cnt < CCW'(CHANNEL_SLOTS));
    assign w_cctl.upd   = w_chan_step;
    assign w_cctl.key   = r_ch;
    assign w_cctl.seq   = r_seq;

    for (genvar gi = 0; gi < CHANNEL_SLOTS; gi++) begin : g_chan
        fsdt_chan_cell u_cell (
            .i_clk   (i_clk),
            .i_live  (CCW'(gi) < r_chan_cnt),
            .i_alloc (w_chan_alloc && (r_chan_cnt == CCW'(gi))),
            .i_ctl   (w_cctl),
            .o_hit   (w_chit[gi]),
            .o_last  (w_clast[gi])
        );
    end

    always_comb begin
        w_chit_last = '0;
        for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            w_chit_last = w_chit_last | (w_chit[i] ? w_clast[i] : '0);
        end
    end

    // ---------------- symbol cells ----------------
    t_sym_ctl                w_sctl;
    logic [SYMBOL_SLOTS-1:0] w_shit;
    logic [SYMBOL_SLOTS:0]   w_free;
    logic [CntW-1:0]         w_strades [SYMBOL_SLOTS];
    logic [SumW-1:0]         w_sqty    [SYMBOL_SLOTS];
    logic [CntW-1:0]         w_hit_trades;
    logic [SumW-1:0]         w_hit_qty;

    assign w_sctl.upd  = (r_state == S_SYM);
    assign w_sctl.miss = (w_shit == '0);
    assign w_sctl.exec = (r_kind == KIND_EXEC);
    assign w_sctl.key  = r_sym;
    assign w_sctl.qty  = r_qty;
    assign w_free[0]   = 1'b0;

    for (genvar gs = 0; gs < SYMBOL_SLOTS; gs++) begin : g_sym
        fsdt_sym_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_sctl),
            .i_free_in  (w_free[gs]),
            .o_free_out (w_free[gs+1]),
            .o_hit      (w_shit[gs]),
            .o_trades   (w_strades[gs]),
            .o_qty      (w_sqty[gs])
        );
    end

    always_comb begin
        w_hit_trades = '0;
        w_hit_qty    = '0;
        for (int i = 0; i < SYMBOL_SLOTS; i++) begin
            w_hit_trades = w_hit_trades | (w_shit[i] ? w_strades[i] : '0);
            w_hit_qty    = w_hit_qty    | (w_shit[i] ? w_sqty[i]    : '0);
        end
    end

    // ---------------- exec id store ----------------
    logic w_issue, w_match, w_scan_done;

    assign w_issue     = (r_state == S_SCAN) && (r_addr < r_seen_cnt);
    assign w_match     = r_pend && (w_rdata == r_id);
    assign w_scan_done = (r_state == S_SCAN) && !w_match && !r_pend && !w_issue;
    assign w_we        = w_scan_done && (r_seen_cnt < DCW'(DEDUP_SLOTS));

    fsdt_ram #(.W(IdW), .D(DEDUP_SLOTS)) u_ids (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_seen_cnt[DAW-1:0]),
        .i_wdata (r_id),
        .i_raddr (r_addr[DAW-1:0]),
        .o_rdata (w_rdata)
    );

    // ---------------- sequencer ----------------
    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_CHAN;
                end
            end
            S_CHAN: begin
                if (r_kind == KIND_EXEC) begin
                    n_state = r_id_ok ? S_SCAN : S_RES;
                end else if (r_kind == KIND_EOD) begin
                    n_state = S_SYM;
                end else begin
                    n_state = S_RES;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_state = S_RES;
                end else if (w_scan_done) begin
                    n_state = w_we ? S_SYM : S_RES;
                end
            end
            S_SYM: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // message latch and per-message result flags
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_kind  <= i_s_tuser;
            r_ch_ok <= i_s_tdata[0] && i_s_tdata[17];
            r_ch    <= i_s_tdata[16:1];
            r_seq   <= i_s_tdata[49:18];
            r_id_ok <= i_s_tdata[50];
            r_id    <= i_s_tdata[114:51];
            r_sym   <= i_s_tdata[178:115];
            r_qty   <= i_s_tdata[179] ? {{32{i_s_tdata[211]}}, i_s_tdata[211:180]} : '0;
        end
        if (r_state == S_CHAN) begin
            r_checked <= w_chan_step && (w_chit != '0);
            r_expect  <= (w_chan_step && (w_chit != '0)) ? w_chit_last + SeqW'(1) : '0;
            r_gap     <= w_chan_step && (w_chit != '0)
                         && (r_seq != w_chit_last + SeqW'(1));
            r_new     <= 1'b0;
            r_tally   <= (r_kind == KIND_EOD);
            r_addr    <= '0;
            r_pend    <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_pend <= w_issue;
            r_addr <= r_addr + DCW'(w_issue);
            if (w_we) begin
                r_new   <= 1'b1;
                r_tally <= 1'b1;
            end
        end
    end

    // counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= '0;
            r_seen_cnt <= '0;
        end else begin
            if (w_chan_alloc) begin
                r_chan_cnt <= r_chan_cnt + CCW'(1);
            end
            if (w_we) begin
                r_seen_cnt <= r_seen_cnt + DCW'(1);
            end
        end
    end

    // output register
    logic w_valid;
    assign w_valid = r_tally && (w_shit != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RES && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && w_out_free) begin
            r_out_data <= {4'b0,
                           w_valid ? w_hit_qty : 64'b0,
                           w_valid ? w_hit_trades : 32'b0,
                           w_valid, r_new, r_expect, r_gap, r_checked};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_cnt <= DCW'(DEDUP_SLOTS))
        else $error("id count beyond store depth");
    a_chan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan_cnt <= CCW'(CHANNEL_SLOTS))
        else $error("channel count beyond slots");
    a_chan_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chit))
        else $error("channel key held twice");
    a_sym_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_shit))
        else $error("symbol key held twice");
    a_new_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_new && r_state == S_SYM))
        else $error("id write without tally step");
`endif

endmodule
`default_nettype wire

[bench/feed_sequence_dedup_tally_tb.sv]
// ----------------------------------------------------------------------------
// feed_sequence_dedup_tally_tb: self-checking bench for the feed tally block
// Drives parsed feed messages with random gaps, predicts every result beat
// (sequence check, exec id de-dup, per-symbol tally) and compares each beat.
// ----------------------------------------------------------------------------
`default_nettype none
module feed_sequence_dedup_tally_tb
    import fsdt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCHAN  = 3;
    localparam int NSYM   = 16;
    localparam int NDEDUP = 256;
    localparam logic [KindW-1:0] KIND_OTHER = 2'd2;
    localparam logic [KindW-1:0] KIND_SPARE = 2'd3;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    // one parsed message
    typedef struct {
        logic [KindW-1:0] kind;
        logic             ch_p;
        logic [ChanW-1:0] ch;
        logic             seq_p;
        logic [SeqW-1:0]  seq;
        logic             id_p;
        logic [IdW-1:0]   id;
        logic [SymW-1:0]  sym;
        logic             qty_p;
        logic [QtyW-1:0]  qty;
    } t_msg;

    // one result beat
    typedef struct packed {
        logic            checked;
        logic            gap;
        logic [SeqW-1:0] exp_seq;
        logic            is_new;
        logic            valid;
        logic [CntW-1:0] trades;
        logic [SumW-1:0] total;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [215:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [135:0] o_m_tdata;

    feed_sequence_dedup_tally u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // ch_p, ch, seq_p, seq, id_p, id, sym, qty_p, qty
        .i_s_tuser  (i_s_tuser),   // msg_kind
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // checked, gap, exp_seq, new, valid, trades, total
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic [ChanW-1:0] chan_key  [NCHAN];
    logic [SeqW-1:0]  chan_last [NCHAN];
    int               chan_cnt;
    logic [IdW-1:0]   ids       [NDEDUP];
    int               id_cnt;
    logic             sym_in_use[NSYM];
    logic [SymW-1:0]  sym_key   [NSYM];
    logic [CntW-1:0]  sym_cnt   [NSYM];
    logic [SumW-1:0]  sym_sum   [NSYM];

    t_res   pending_results[$];
    int     errors = 0;
    int     beats_sent = 0, beats_checked = 0;
    int     gaps_seen = 0, new_trades_seen = 0;
    longint cycles = 0;

    // ids partly reused from earlier ones, symbols drawn from a small pool, so repeats happen
    logic [IdW-1:0]  id_pool  [$];
    logic [SymW-1:0] sym_pool [24];
    logic [ChanW-1:0] chan_pool[5];
    logic [SeqW-1:0]  next_seq [5];

    function automatic int sym_slot(input logic [SymW-1:0] key);
        for (int i = 0; i < NSYM; i++)
            if (sym_in_use[i] && sym_key[i] == key) return i;
        for (int i = 0; i < NSYM; i++)
            if (!sym_in_use[i]) begin
                sym_in_use[i] = 1'b1;
                sym_key[i]    = key;
                sym_cnt[i]    = '0;
                sym_sum[i]    = '0;
                return i;
            end
        return -1;
    endfunction

    function automatic bit record_id(input logic [IdW-1:0] id);
        for (int i = 0; i < id_cnt; i++)
            if (ids[i] == id) return 1'b0;
        if (id_cnt >= NDEDUP) return 1'b0;
        ids[id_cnt] = id;
        id_cnt++;
        return 1'b1;
    endfunction

    function automatic t_res tally_message(input t_msg m);
        t_res r;
        int slot;
        bit hit;
        logic [SumW-1:0] q64;
        r = '{default: '0};
        slot = -1;
        hit = 1'b0;
        q64 = m.qty_p ? {{32{m.qty[31]}}, m.qty} : '0;
        if (m.ch_p && m.seq_p) begin
            for (int i = 0; i < chan_cnt && !hit; i++)
                if (chan_key[i] == m.ch) begin
                    r.exp_seq    = chan_last[i] + 1;
                    r.checked    = 1'b1;
                    r.gap        = (m.seq != r.exp_seq);
                    chan_last[i] = m.seq;
                    hit = 1'b1;
                end
            if (!hit && chan_cnt < NCHAN) begin
                chan_key[chan_cnt]  = m.ch;
                chan_last[chan_cnt] = m.seq;
                chan_cnt++;
            end
        end
        if (m.kind == KIND_EXEC) begin
            if (m.id_p && record_id(m.id)) begin
                r.is_new = 1'b1;
                slot = sym_slot(m.sym);
                if (slot >= 0) begin
                    if (sym_cnt[slot] != '1) sym_cnt[slot]++;
                    sym_sum[slot] += q64;
                end
            end
        end else if (m.kind == KIND_EOD) begin
            slot = sym_slot(m.sym);
        end
        if (slot >= 0) begin
            r.valid  = 1'b1;
            r.trades = sym_cnt[slot];
            r.total  = sym_sum[slot];
        end
        return r;
    endfunction

    // ---------------- driver ----------------
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid drops at the negedge after the accept; the next beat starts at a
    // later negedge at the earliest and is held until the block is ready again
    task automatic send_message(input t_msg m);
        repeat (1 + pick_gap()) @(negedge i_clk);
        i_s_tuser  <= m.kind;
        i_s_tdata  <= {4'b0, m.qty, m.qty_p, m.sym, m.id, m.id_p,
                       m.seq, m.seq_p, m.ch, m.ch_p};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(tally_message(m));
        beats_sent++;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // receiver stalls
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            g = pick_gap();
            if ($urandom_range(0, 3) == 0 && cycles > 200 && g > 0) begin
                i_m_tready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_res e, a;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            a.checked = o_m_tdata[0];
            a.gap     = o_m_tdata[1];
            a.exp_seq = o_m_tdata[33:2];
            a.is_new  = o_m_tdata[34];
            a.valid   = o_m_tdata[35];
            a.trades  = o_m_tdata[67:36];
            a.total   = o_m_tdata[131:68];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result beat with none expected");
            end else begin
                e = pending_results.pop_front();
                beats_checked++;
                if (a.gap) gaps_seen++;
                if (a.is_new) new_trades_seen++;
                if (a !== e) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR beat %0d: exp chk%0b gap%0b seq%h new%0b v%0b n%h q%h",
                                 beats_checked, e.checked, e.gap, e.exp_seq, e.is_new,
                                 e.valid, e.trades, e.total,
                                 "\n      got chk%0b gap%0b seq%h new%0b v%0b n%h q%h",
                                 a.checked, a.gap, a.exp_seq, a.is_new,
                                 a.valid, a.trades, a.total);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- message builders ----------------
    function automatic t_msg quiet_msg(input logic [KindW-1:0] kind);
        t_msg m;
        m = '{default: '0};
        m.kind = kind;
        return m;
    endfunction

    function automatic t_msg random_msg();
        t_msg m;
        int c, p;
        m.kind  = ($urandom_range(0, 9) < 7) ? KIND_EXEC :
                  ($urandom_range(0, 2) == 0) ? KIND_EOD :
                  ($urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE);
        c       = $urandom_range(0, 4);
        m.ch_p  = ($urandom_range(0, 9) != 0);
        m.ch    = ($urandom_range(0, 19) == 0) ? 16'($urandom) : chan_pool[c];
        m.seq_p = ($urandom_range(0, 9) != 0);
        p = $urandom_range(0, 9);
        // mostly in order; some gaps, repeats and random values
        m.seq = (p < 7) ? next_seq[c] : (p < 8) ? next_seq[c] + 5 :
                (p < 9) ? next_seq[c] - 1 : $urandom;
        next_seq[c] = m.seq + 1;
        m.id_p  = ($urandom_range(0, 19) != 0);
        if (id_pool.size() > 0 && $urandom_range(0, 3) == 0)
            m.id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else begin
            m.id = {$urandom, $urandom};
            id_pool.push_back(m.id);
        end
        m.sym   = sym_pool[$urandom_range(0, 23)];
        m.qty_p = ($urandom_range(0, 9) != 0);
        m.qty   = $urandom;
        return m;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        t_msg m;
        // unseen channel, then in order, wrap, gap
        m = quiet_msg(KIND_OTHER); m.ch_p = 1'b1; m.seq_p = 1'b1;
        m.ch = 16'hFFFF; m.seq = 32'hFFFF_FFFE; send_message(m);
        m.seq = 32'hFFFF_FFFF; send_message(m);
        m.seq = 32'h0;         send_message(m);
        m.seq = 32'h5;         send_message(m);
        m.kind = KIND_SPARE; m.seq = 32'h6; send_message(m);
        // channel or sequence absent
        m.seq_p = 1'b0; send_message(m);
        m.seq_p = 1'b1; m.ch_p = 1'b0; send_message(m);
        // fill channel slots, then an ignored fourth channel
        m.ch_p = 1'b1; m.ch = 16'h0000; m.seq = 32'h0; send_message(m);
        m.ch = 16'h1234; send_message(m);
        m.ch = 16'h4321; send_message(m);
        m.ch = 16'h4321; send_message(m);
        // executions: extreme quantities, repeat id, absent id/qty
        m = quiet_msg(KIND_EXEC); m.id_p = 1'b1; m.qty_p = 1'b1;
        m.id = '1; m.sym = '1; m.qty = 32'h7FFF_FFFF; send_message(m);
        m.id = '0; m.qty = 32'h8000_0000; send_message(m);
        m.id = '1; send_message(m);
        m.id = 64'h1; m.qty_p = 1'b0; m.qty = 32'hFFFF_FFFF; send_message(m);
        m.id_p = 1'b0; m.id = 64'h2; send_message(m);
        m.id_p = 1'b1; m.sym = '0; m.qty_p = 1'b1; m.qty = 32'hFFFF_FFFF; send_message(m);
        // end of day: known and new symbol
        m = quiet_msg(KIND_EOD); m.sym = '1; send_message(m);
        m.sym = 64'hA5A5; send_message(m);
    endtask

    task automatic test_symbol_table_full();
        t_msg m;
        // allocate past capacity through end-of-day beats
        m = quiet_msg(KIND_EOD);
        for (int i = 0; i < NSYM; i++) begin
            m.sym = 64'hF000 + i;
            send_message(m);
        end
        m = quiet_msg(KIND_EXEC); m.id_p = 1'b1; m.id = 64'hDEAD_0001;
        m.sym = 64'hBEEF; send_message(m);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_message(random_msg());
    endtask

    task automatic test_id_store_full();
        t_msg m;
        // push fresh ids until the store is full, then random messages with new and repeated ids
        m = quiet_msg(KIND_EXEC); m.id_p = 1'b1; m.qty_p = 1'b1;
        while (id_cnt < NDEDUP + 4) begin
            m.id  = {$urandom, $urandom};
            m.sym = sym_pool[$urandom_range(0, 3)];
            m.qty = $urandom;
            send_message(m);
            if (id_cnt == NDEDUP) break;
        end
        for (int i = 0; i < 20; i++) send_message(random_msg());
    endtask

    initial begin
        for (int i = 0; i < 24; i++) sym_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 5; i++) begin
            chan_pool[i] = 16'($urandom);
            next_seq[i]  = $urandom;
        end
        chan_cnt = 0;
        id_cnt   = 0;
        for (int i = 0; i < NSYM; i++) sym_in_use[i] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(700);
        test_symbol_table_full();
        test_id_store_full();
        test_random(1150);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NDEDUP + 20) @(posedge i_clk);

        $display("Covered %0d messages, %0d results: %0d gaps, %0d new trades.",
                 beats_sent, beats_checked, gaps_seen, new_trades_seen);
        $display("Channel, id and symbol stores all filled past capacity.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
